/* src/dq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int REQ_W          = 3;
  localparam int WORD_W         = 32;
  localparam int STATUS_W       = 2;
  localparam int COUNT_W        = 11;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK       = 3'd4
  } dq_req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_FILL = 4'b0100,
    S_DONE = 4'b1000
  } dq_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic fill;
  } dq_cmd_t;

  typedef struct packed {
    logic fill_req;
  } dq_stat_t;

endpackage

/* src/dq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl
// Request sequencer: accept, execute, optional store refill, result strobe.
// ----------------------------------------------------------------------------
module dq_ctrl
  import dq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  output dq_cmd_t  cmd,
  input  dq_stat_t stat
);

  dq_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: state_nxt = stat.fill_req ? S_FILL : S_DONE;
      S_FILL: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign cmd.load  = (state_r == S_IDLE) && start;
  assign cmd.exec  = (state_r == S_EXEC);
  assign cmd.fill  = (state_r == S_FILL);

endmodule

/* src/dq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_dp
// Ring-buffer store, indices, count and cached front/back words.
// ----------------------------------------------------------------------------
module dq_dp
  import dq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dq_cmd_t                    cmd,
  output dq_stat_t                   stat,
  input  logic        [REQ_W-1:0]    in_req_type,
  input  logic signed [WORD_W-1:0]   in_data_in,
  output logic signed [WORD_W-1:0]   out_pop_value,
  output logic        [STATUS_W-1:0] out_status,
  output logic        [COUNT_W-1:0]  out_count,
  output logic                       out_is_empty,
  output logic signed [WORD_W-1:0]   out_front_value,
  output logic signed [WORD_W-1:0]   out_back_value
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [REQ_W-1:0]      req_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [AW-1:0]         front_idx_r, front_idx_nxt;
  logic [AW-1:0]         back_idx_r, back_idx_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [DATA_WIDTH-1:0] front_val_r, front_val_nxt;
  logic [DATA_WIDTH-1:0] back_val_r, back_val_nxt;
  logic [DATA_WIDTH-1:0] pop_val_r, pop_val_nxt;
  logic                  pop_hit_r, pop_hit_nxt;
  dq_status_t            status_r, status_nxt;
  logic                  fill_front_r, fill_front_nxt;
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic                  wr_en;
  logic                  full, empty;

  logic signed [DATA_WIDTH-1:0] pop_s, front_s, back_s;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
  endfunction

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    front_idx_nxt  = front_idx_r;
    back_idx_nxt   = back_idx_r;
    count_nxt      = count_r;
    front_val_nxt  = front_val_r;
    back_val_nxt   = back_val_r;
    pop_val_nxt    = front_val_r;
    pop_hit_nxt    = 1'b0;
    status_nxt     = ST_OK;
    fill_front_nxt = 1'b1;
    rd_addr        = idx_inc(front_idx_r);
    wr_addr        = back_idx_r;
    wr_en          = 1'b0;
    stat.fill_req  = 1'b0;
    unique case (req_r)
      REQ_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          front_idx_nxt = idx_dec(front_idx_r);
          wr_addr       = idx_dec(front_idx_r);
          wr_en         = cmd.exec;
          front_val_nxt = data_r;
          if (empty) back_val_nxt = data_r;
          count_nxt     = count_r + CW'(1);
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          back_idx_nxt  = idx_inc(back_idx_r);
          wr_addr       = back_idx_r;
          wr_en         = cmd.exec;
          back_val_nxt  = data_r;
          if (empty) front_val_nxt = data_r;
          count_nxt     = count_r + CW'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          pop_val_nxt    = front_val_r;
          pop_hit_nxt    = 1'b1;
          front_idx_nxt  = idx_inc(front_idx_r);
          rd_addr        = idx_inc(front_idx_r);
          fill_front_nxt = 1'b1;
          count_nxt      = count_r - CW'(1);
          stat.fill_req  = (count_r != CW'(1));
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          pop_val_nxt    = back_val_r;
          pop_hit_nxt    = 1'b1;
          back_idx_nxt   = idx_dec(back_idx_r);
          rd_addr        = idx_dec(idx_dec(back_idx_r));
          fill_front_nxt = 1'b0;
          count_nxt      = count_r - CW'(1);
          stat.fill_req  = (count_r != CW'(1));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= data_r;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_idx_r <= '0;
      back_idx_r  <= '0;
      count_r     <= '0;
    end else if (cmd.exec) begin
      front_idx_r <= front_idx_nxt;
      back_idx_r  <= back_idx_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      data_r <= DATA_WIDTH'($unsigned(in_data_in));
    end
    if (cmd.exec) begin
      front_val_r  <= front_val_nxt;
      back_val_r   <= back_val_nxt;
      pop_val_r    <= pop_val_nxt;
      pop_hit_r    <= pop_hit_nxt;
      status_r     <= status_nxt;
      fill_front_r <= fill_front_nxt;
    end else if (cmd.fill) begin
      if (fill_front_r) begin
        front_val_r <= rd_data_r;
      end else begin
        back_val_r <= rd_data_r;
      end
    end
  end

  assign pop_s   = pop_val_r;
  assign front_s = front_val_r;
  assign back_s  = back_val_r;

  assign out_pop_value   = pop_hit_r ? WORD_W'(pop_s) : '1;
  assign out_status      = status_r;
  assign out_count       = COUNT_W'(count_r);
  assign out_is_empty    = empty;
  assign out_front_value = empty ? '1 : WORD_W'(front_s);
  assign out_back_value  = empty ? '1 : WORD_W'(back_s);

endmodule

/* src/double_ended_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// The result strobe follows the execute state, and also a refill state for a pop
// that leaves words behind (store read of the new end).
// A new request is taken only once the last one is through; busy covers the
// execute, refill and result cycles of the sequencer.
// Reset clears indices and count; store contents are not cleared.
// The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic        [REQ_W-1:0]    in_req_type,
  input  logic signed [WORD_W-1:0]   in_data_in,
  output logic                       out_valid,
  output logic signed [WORD_W-1:0]   out_pop_value,
  output logic        [STATUS_W-1:0] out_status,
  output logic        [COUNT_W-1:0]  out_count,
  output logic                       out_is_empty,
  output logic signed [WORD_W-1:0]   out_front_value,
  output logic signed [WORD_W-1:0]   out_back_value
);

  dq_cmd_t  cmd;
  dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  dq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_req_type),
    .in_data_in      (in_data_in),
    .out_pop_value   (out_pop_value),
    .out_status      (out_status),
    .out_count       (out_count),
    .out_is_empty    (out_is_empty),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value)
  );

endmodule
